// File: design/cbd_pkg.sv
// shared types, constants and helpers for the chunked body decoder
`timescale 1ns / 1ps
package cbd_pkg;

  localparam int CBD_SIZE_BITS = 32;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } cbd_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [31:0] consumed;
  } cbd_out_t;

  // one result word from the decode stage to the output stage
  typedef struct packed {
    logic     valid;
    cbd_out_t data;
  } cbd_res_t;

  // hex digit decode: valid flag plus nibble value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: design/cbd_core.sv
// decode state machine: size line parsing, data pass-through, skip of the two bytes after each chunk's data
`timescale 1ns / 1ps
module cbd_core #(
  parameter int SIZE_BITS = cbd_pkg::CBD_SIZE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  cbd_pkg::cbd_in_t  word,
  output cbd_pkg::cbd_res_t res
);
  import cbd_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LEAD  = 3'd1;
  localparam logic [2:0] PH_HEX   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SKIP1 = 3'd4;
  localparam logic [2:0] PH_SKIP2 = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;
  localparam logic [2:0] PH_ERR   = 3'd7;

  logic [2:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] remaining_r, remaining_nxt;
  logic                 digits_ended_r, digits_ended_nxt;
  logic                 saw_cr_r, saw_cr_nxt;
  logic [31:0]          offset_r, offset_nxt;

  logic [SIZE_BITS-1:0] rem_dec;
  logic [31:0]          offset_inc;
  logic [4:0]           hex;
  logic [7:0]           b;

  assign b          = word.in_byte;
  assign rem_dec    = remaining_r - {{(SIZE_BITS-1){1'b0}}, 1'b1};
  assign offset_inc = offset_r + 32'd1;
  assign hex        = hex_decode(b);

  always_comb begin
    phase_nxt        = phase_r;
    remaining_nxt    = remaining_r;
    digits_ended_nxt = digits_ended_r;
    saw_cr_nxt       = saw_cr_r;
    offset_nxt       = offset_r;
    res              = '0;
    if (fire) begin
      if (word.op == OP_START) begin
        offset_nxt       = '0;
        phase_nxt        = PH_LEAD;
        remaining_nxt    = '0;
        digits_ended_nxt = 1'b0;
        saw_cr_nxt       = 1'b0;
      end else if (phase_r != PH_IDLE && phase_r != PH_DONE && phase_r != PH_ERR) begin
        offset_nxt = offset_inc;
        unique case (phase_r)
          PH_DATA: begin
            remaining_nxt = rem_dec;
            if (rem_dec == '0) phase_nxt = PH_SKIP1;
            res.valid         = 1'b1;
            res.data.out_byte = b;
            res.data.kind     = KIND_PAYLOAD;
          end
          PH_SKIP1: phase_nxt = PH_SKIP2;
          PH_SKIP2: begin
            phase_nxt        = PH_LEAD;
            remaining_nxt    = '0;
            digits_ended_nxt = 1'b0;
            saw_cr_nxt       = 1'b0;
          end
          PH_LEAD, PH_HEX: begin
            if (saw_cr_r && b == CHAR_LF) begin
              // end of size line
              saw_cr_nxt       = 1'b0;
              digits_ended_nxt = 1'b0;
              if (remaining_r == '0) begin
                phase_nxt         = PH_DONE;
                res.valid         = 1'b1;
                res.data.kind     = KIND_COMPLETE;
                res.data.consumed = offset_inc;
              end else begin
                phase_nxt = PH_DATA;
              end
            end else begin
              saw_cr_nxt = (b == CHAR_CR);
              if (!digits_ended_r &&
                  !(phase_r == PH_LEAD && (b == CHAR_SP || b == CHAR_TAB))) begin
                phase_nxt = PH_HEX;
                if (!hex[4]) begin
                  digits_ended_nxt = 1'b1;
                end else if (remaining_r[SIZE_BITS-1 -: 4] != 4'd0) begin
                  phase_nxt     = PH_ERR;
                  res.valid     = 1'b1;
                  res.data.kind = KIND_OVERFLOW;
                end else begin
                  remaining_nxt = {remaining_r[SIZE_BITS-5:0], hex[3:0]};
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      remaining_r    <= '0;
      digits_ended_r <= 1'b0;
      saw_cr_r       <= 1'b0;
      offset_r       <= '0;
    end else begin
      phase_r        <= phase_nxt;
      remaining_r    <= remaining_nxt;
      digits_ended_r <= digits_ended_nxt;
      saw_cr_r       <= saw_cr_nxt;
      offset_r       <= offset_nxt;
    end
  end

endmodule

// File: design/cbd_out_stage.sv
// output register with one skid entry
`timescale 1ns / 1ps
module cbd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  cbd_pkg::cbd_res_t res,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output cbd_pkg::cbd_out_t out_data
);
  import cbd_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  cbd_out_t out_data_r, out_data_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  cbd_out_t skid_data_r, skid_data_nxt;

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      // output slot frees up: drain skid first, else take the new word
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res.valid;
        if (res.valid) out_data_nxt = res.data;
      end
    end else if (res.valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// File: design/chunked_body_decoder_unit.sv
// top level of the chunked body decoder
`timescale 1ns / 1ps
// usage:
//   in_valid / in_stall / in_data carry one word per accepted edge: either a
//   start word (op = start) that clears the decoder, or one raw body byte
//   out_valid / out_stall / out_data deliver at most one result per input
//   word: a payload byte, a body-complete word with the consumed count, or a
//   chunk size overflow error
// output: each result is registered in the output register, or in the skid entry while out_data is held
// throughput: one word per cycle while in_stall is low, set by the single decode state update;
//   the decode state moves in the same cycle the word is accepted
// stalls: the output register plus one skid entry let the decoder take a
//   word while a result waits; in_stall rises only when the skid entry is
//   occupied and falls once the receiver takes the waiting result
// reset: synchronous active-low rst_n returns the decoder to idle; bytes
//   before a start word are dropped without effect
module chunked_body_decoder_unit #(
  parameter int SIZE_BITS = cbd_pkg::CBD_SIZE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cbd_pkg::cbd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cbd_pkg::cbd_out_t out_data
);
  import cbd_pkg::*;

  logic     in_fire;
  logic     skid_full;
  cbd_res_t res;

  // input side stalls only on a full skid entry
  assign in_stall = skid_full;
  assign in_fire  = in_valid && !skid_full;

  cbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (in_fire),
    .word (in_data),
    .res  (res)
  );

  cbd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .full     (skid_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
